@@ hdl/tls_record_handshake_deframer_top_macros.svh @@
// assertion macros for the tls record deframer
`ifndef TLS_RECORD_HANDSHAKE_DEFRAMER_TOP_MACROS_SVH
`define TLS_RECORD_HANDSHAKE_DEFRAMER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge out of reset
`define TLSD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);
// condition must never be seen out of reset
`define TLSD_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);
`else
`define TLSD_ASSERT(lbl, prop, msg)
`define TLSD_NEVER(lbl, cond, msg)
`endif

`endif

@@ hdl/tlsd_pkg.sv @@
// types and constants of the tls record deframer
package tlsd_pkg;

	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_RECORD_LEN    = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MIN_MAJOR_VERSION = 8'd1;

	localparam logic [15:0] MAX_RECORD_LEN_RST    = 16'd16384;
	localparam logic [7:0]  MIN_MAJOR_VERSION_RST = 8'd3;

	localparam logic [7:0] HANDSHAKE_TYPE = 8'd22;

	// byte positions inside the record and message headers
	localparam logic [2:0] REC_HDR_TYPE  = 3'd0;
	localparam logic [2:0] REC_HDR_MAJOR = 3'd1;
	localparam logic [2:0] REC_HDR_MINOR = 3'd2;
	localparam logic [2:0] REC_HDR_LEN_H = 3'd3;
	localparam logic [1:0] MSG_HDR_TYPE  = 2'd0;
	localparam logic [1:0] MSG_HDR_LAST  = 2'd3;

	typedef enum logic [2:0] {
		PH_RECHDR  = 3'd0,
		PH_PAYLOAD = 3'd1,
		PH_MSGHDR  = 3'd2,
		PH_MSGBODY = 3'd3,
		PH_DISCARD = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		KIND_REC_HDR = 3'd0,
		KIND_PAYLOAD = 3'd1,
		KIND_HS_HDR  = 3'd2,
		KIND_HS_BODY = 3'd3,
		KIND_DISCARD = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE        = 3'd0,
		ERR_BAD_VERSION = 3'd1,
		ERR_TOO_LONG    = 3'd2,
		ERR_HS_TRUNC    = 3'd3,
		ERR_HS_OVERRUN  = 3'd4
	} err_t;

endpackage

@@ hdl/tlsd_byte_if.sv @@
// byte stream channel into the deframer
interface tlsd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;

	modport source (output valid, output byte_value, input ready);
	modport sink (input valid, input byte_value, output ready);
endinterface

@@ hdl/tlsd_result_if.sv @@
// per-byte result channel out of the deframer
interface tlsd_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  byte_kind;
	logic [7:0]  content_type;
	logic [7:0]  version_major;
	logic [7:0]  version_minor;
	logic [15:0] payload_len;
	logic [7:0]  message_type;
	logic [23:0] message_len;
	logic        record_last;
	logic        message_last;
	logic [2:0]  error_code;

	modport source (
		output valid, output byte_kind, output content_type, output version_major,
		output version_minor, output payload_len, output message_type,
		output message_len, output record_last, output message_last,
		output error_code, input ready
	);
	modport sink (
		input valid, input byte_kind, input content_type, input version_major,
		input version_minor, input payload_len, input message_type,
		input message_len, input record_last, input message_last,
		input error_code, output ready
	);
endinterface

@@ hdl/tlsd_cfg_if.sv @@
// register write channel of the deframer
interface tlsd_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [tlsd_pkg::CFG_INDEX_W-1:0] index;
	logic [tlsd_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/tls_record_handshake_deframer_top.sv @@
// tls record deframer with handshake message header parsing
// Takes a TLS byte stream one byte per request on the stream channel and
// returns one result request per byte on the result channel: the byte's
// kind (record header, other payload, handshake header, handshake body or
// discarded), the fields of the current record header and handshake message
// header, end-of-record and end-of-message marks, and an error code. The
// record header's major version is checked against min_major_version and
// its length against max_record_len (registers 1 and 0 of the write channel,
// reset to 3 and 16384); inside handshake records a message header cut by
// the record end, or a message body longer than what is left of the record,
// is an error. After any error every later byte is discarded until reset.
// Throughput is one byte per clock unless the result side stalls; the parse is
// a single pass of compares and counters into one result register, and the
// stream side stalls only while that register holds a result not yet taken.
`include "tls_record_handshake_deframer_top_macros.svh"

module tls_record_handshake_deframer_top (
	input  logic          clk,
	input  logic          arst_n,
	tlsd_byte_if.sink     stream,
	tlsd_result_if.source result,
	tlsd_cfg_if.sink      cfg
);

	// configuration registers
	logic [15:0] max_len_q;
	logic [7:0]  min_major_q;

	// parser state
	tlsd_pkg::phase_t phase_q, phase_n;
	logic [2:0]  hdr_idx_q, hdr_idx_n;
	logic [7:0]  type_q, type_n;
	logic [7:0]  major_q, major_n;
	logic [7:0]  minor_q, minor_n;
	logic [15:0] rec_len_q, rec_len_n;
	logic [15:0] rec_rem_q, rec_rem_n;
	logic [1:0]  msg_idx_q, msg_idx_n;
	logic [7:0]  hs_type_q, hs_type_n;
	logic [23:0] msg_len_q, msg_len_n;
	logic [23:0] msg_rem_q, msg_rem_n;
	tlsd_pkg::err_t err_q, err_n;

	// per-byte outcome
	tlsd_pkg::kind_t kind;
	tlsd_pkg::err_t  err;
	logic            rec_last;
	logic            msg_last;

	// helpers
	logic [7:0]  b;
	logic [15:0] rec_rem_dec;
	logic [23:0] msg_rem_dec;
	logic [15:0] hdr_len;
	logic [23:0] msg_len_full;

	// result register
	logic            res_valid_q;
	tlsd_pkg::kind_t res_kind_q;
	logic [7:0]      res_type_q;
	logic [7:0]      res_major_q;
	logic [7:0]      res_minor_q;
	logic [15:0]     res_rec_len_q;
	logic [7:0]      res_hs_type_q;
	logic [23:0]     res_msg_len_q;
	logic            res_rec_last_q;
	logic            res_msg_last_q;
	tlsd_pkg::err_t  res_err_q;

	logic in_acc;

	// take a byte whenever the result register is empty or draining
	assign stream.ready = !res_valid_q || result.ready;
	assign in_acc       = stream.valid && stream.ready;
	assign cfg.ready    = 1'b1;

	assign b            = stream.byte_value;
	assign rec_rem_dec  = rec_rem_q - 16'd1;
	assign msg_rem_dec  = msg_rem_q - 24'd1;
	// high length byte was parked in rec_rem_q[15:8] on header byte 3
	assign hdr_len      = {rec_rem_q[15:8], b};
	assign msg_len_full = {msg_rem_q[15:0], b};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q   <= tlsd_pkg::MAX_RECORD_LEN_RST;
			min_major_q <= tlsd_pkg::MIN_MAJOR_VERSION_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				tlsd_pkg::CFG_MAX_RECORD_LEN: max_len_q <= cfg.data;
				tlsd_pkg::CFG_MIN_MAJOR_VERSION: min_major_q <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	// next state and per-byte outcome
	always_comb begin
		phase_n    = phase_q;
		hdr_idx_n  = hdr_idx_q;
		type_n     = type_q;
		major_n    = major_q;
		minor_n    = minor_q;
		rec_len_n  = rec_len_q;
		rec_rem_n  = rec_rem_q;
		msg_idx_n  = msg_idx_q;
		hs_type_n  = hs_type_q;
		msg_len_n  = msg_len_q;
		msg_rem_n  = msg_rem_q;
		err_n      = err_q;
		kind       = tlsd_pkg::KIND_DISCARD;
		err        = tlsd_pkg::ERR_NONE;
		rec_last   = 1'b0;
		msg_last   = 1'b0;

		case (phase_q)
			tlsd_pkg::PH_RECHDR: begin
				kind = tlsd_pkg::KIND_REC_HDR;
				case (hdr_idx_q)
					tlsd_pkg::REC_HDR_TYPE: begin
						// first header byte wipes the previous record
						type_n     = b;
						major_n    = 8'd0;
						minor_n    = 8'd0;
						rec_len_n  = 16'd0;
						rec_rem_n  = 16'd0;
						msg_idx_n  = 2'd0;
						hs_type_n  = 8'd0;
						msg_len_n  = 24'd0;
						msg_rem_n  = 24'd0;
						hdr_idx_n  = tlsd_pkg::REC_HDR_MAJOR;
					end
					tlsd_pkg::REC_HDR_MAJOR: begin
						major_n   = b;
						hdr_idx_n = tlsd_pkg::REC_HDR_MINOR;
					end
					tlsd_pkg::REC_HDR_MINOR: begin
						minor_n   = b;
						hdr_idx_n = tlsd_pkg::REC_HDR_LEN_H;
					end
					tlsd_pkg::REC_HDR_LEN_H: begin
						rec_rem_n = {b, 8'd0};
						hdr_idx_n = hdr_idx_q + 3'd1;
					end
					default: begin
						// last header byte: checks, then pick the payload phase
						rec_rem_n = 16'd0;
						hdr_idx_n = tlsd_pkg::REC_HDR_TYPE;
						if (major_q < min_major_q) begin
							err     = tlsd_pkg::ERR_BAD_VERSION;
							err_n   = err;
							phase_n = tlsd_pkg::PH_DISCARD;
						end else if (hdr_len > max_len_q) begin
							err     = tlsd_pkg::ERR_TOO_LONG;
							err_n   = err;
							phase_n = tlsd_pkg::PH_DISCARD;
						end else begin
							rec_len_n = hdr_len;
							rec_rem_n = hdr_len;
							if (hdr_len == 16'd0) begin
								rec_last = 1'b1;
							end else if (type_q == tlsd_pkg::HANDSHAKE_TYPE) begin
								phase_n   = tlsd_pkg::PH_MSGHDR;
								msg_idx_n = tlsd_pkg::MSG_HDR_TYPE;
							end else begin
								phase_n = tlsd_pkg::PH_PAYLOAD;
							end
						end
					end
				endcase
			end

			tlsd_pkg::PH_PAYLOAD: begin
				kind      = tlsd_pkg::KIND_PAYLOAD;
				rec_rem_n = rec_rem_dec;
				if (rec_rem_dec == 16'd0) begin
					rec_last  = 1'b1;
					phase_n   = tlsd_pkg::PH_RECHDR;
					hdr_idx_n = tlsd_pkg::REC_HDR_TYPE;
				end
			end

			tlsd_pkg::PH_MSGHDR: begin
				kind      = tlsd_pkg::KIND_HS_HDR;
				rec_rem_n = rec_rem_dec;
				if (msg_idx_q == tlsd_pkg::MSG_HDR_TYPE) begin
					hs_type_n  = b;
					msg_len_n  = 24'd0;
					msg_rem_n  = 24'd0;
				end else if (msg_idx_q != tlsd_pkg::MSG_HDR_LAST) begin
					msg_rem_n = {msg_rem_q[15:0], b};
				end
				if (msg_idx_q != tlsd_pkg::MSG_HDR_LAST) begin
					msg_idx_n = msg_idx_q + 2'd1;
					// record ends inside the message header
					if (rec_rem_dec == 16'd0) begin
						err     = tlsd_pkg::ERR_HS_TRUNC;
						err_n   = err;
						phase_n = tlsd_pkg::PH_DISCARD;
					end
				end else begin
					msg_idx_n = tlsd_pkg::MSG_HDR_TYPE;
					msg_rem_n = 24'd0;
					if (msg_len_full > {8'd0, rec_rem_dec}) begin
						err     = tlsd_pkg::ERR_HS_OVERRUN;
						err_n   = err;
						phase_n = tlsd_pkg::PH_DISCARD;
					end else begin
						msg_len_n = msg_len_full;
						msg_rem_n = msg_len_full;
						if (msg_len_full == 24'd0) begin
							// empty message ends on its header
							msg_last = 1'b1;
							if (rec_rem_dec == 16'd0) begin
								rec_last  = 1'b1;
								phase_n   = tlsd_pkg::PH_RECHDR;
								hdr_idx_n = tlsd_pkg::REC_HDR_TYPE;
							end
						end else begin
							phase_n = tlsd_pkg::PH_MSGBODY;
						end
					end
				end
			end

			tlsd_pkg::PH_MSGBODY: begin
				kind      = tlsd_pkg::KIND_HS_BODY;
				rec_rem_n = rec_rem_dec;
				msg_rem_n = msg_rem_dec;
				if (msg_rem_dec == 24'd0) begin
					msg_last = 1'b1;
					if (rec_rem_dec == 16'd0) begin
						rec_last  = 1'b1;
						phase_n   = tlsd_pkg::PH_RECHDR;
						hdr_idx_n = tlsd_pkg::REC_HDR_TYPE;
					end else begin
						phase_n   = tlsd_pkg::PH_MSGHDR;
						msg_idx_n = tlsd_pkg::MSG_HDR_TYPE;
					end
				end else if (rec_rem_dec == 16'd0) begin
					err     = tlsd_pkg::ERR_HS_OVERRUN;
					err_n   = err;
					phase_n = tlsd_pkg::PH_DISCARD;
				end
			end

			default: begin
				// discarding until reset, sticky code repeated
				kind = tlsd_pkg::KIND_DISCARD;
				err  = err_q;
			end
		endcase
	end

	// parser state registers, advanced once per accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= tlsd_pkg::PH_RECHDR;
			hdr_idx_q  <= tlsd_pkg::REC_HDR_TYPE;
			type_q     <= 8'd0;
			major_q    <= 8'd0;
			minor_q    <= 8'd0;
			rec_len_q  <= 16'd0;
			rec_rem_q  <= 16'd0;
			msg_idx_q  <= tlsd_pkg::MSG_HDR_TYPE;
			hs_type_q  <= 8'd0;
			msg_len_q  <= 24'd0;
			msg_rem_q  <= 24'd0;
			err_q      <= tlsd_pkg::ERR_NONE;
		end else if (in_acc) begin
			phase_q    <= phase_n;
			hdr_idx_q  <= hdr_idx_n;
			type_q     <= type_n;
			major_q    <= major_n;
			minor_q    <= minor_n;
			rec_len_q  <= rec_len_n;
			rec_rem_q  <= rec_rem_n;
			msg_idx_q  <= msg_idx_n;
			hs_type_q  <= hs_type_n;
			msg_len_q  <= msg_len_n;
			msg_rem_q  <= msg_rem_n;
			err_q      <= err_n;
		end
	end

	// result register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (in_acc) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// result payload, fields show the state after this byte
	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_kind_q     <= kind;
			res_type_q     <= type_n;
			res_major_q    <= major_n;
			res_minor_q    <= minor_n;
			res_rec_len_q  <= rec_len_n;
			res_hs_type_q  <= hs_type_n;
			res_msg_len_q  <= msg_len_n;
			res_rec_last_q <= rec_last;
			res_msg_last_q <= msg_last;
			res_err_q      <= err;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.byte_kind     = res_kind_q;
	assign result.content_type  = res_type_q;
	assign result.version_major = res_major_q;
	assign result.version_minor = res_minor_q;
	assign result.payload_len   = res_rec_len_q;
	assign result.message_type  = res_hs_type_q;
	assign result.message_len   = res_msg_len_q;
	assign result.record_last   = res_rec_last_q;
	assign result.message_last  = res_msg_last_q;
	assign result.error_code    = res_err_q;

	// discarding is permanent until reset
	`TLSD_ASSERT(a_discard_sticks, phase_q == tlsd_pkg::PH_DISCARD |=> phase_q == tlsd_pkg::PH_DISCARD, "left discard phase without reset")

	// a byte taken while discarding comes out as discarded with a code
	`TLSD_ASSERT(a_discard_result, (in_acc && phase_q == tlsd_pkg::PH_DISCARD) |=> (res_kind_q == tlsd_pkg::KIND_DISCARD && res_err_q != tlsd_pkg::ERR_NONE), "discarded byte without kind or code")

	// an error byte never carries end marks
	`TLSD_NEVER(a_err_no_marks, res_valid_q && res_err_q != tlsd_pkg::ERR_NONE && (res_rec_last_q || res_msg_last_q), "end mark on an error byte")

	// record end returns to the first header byte
	`TLSD_ASSERT(a_rec_end_rewinds, (in_acc && rec_last) |=> (phase_q == tlsd_pkg::PH_RECHDR && hdr_idx_q == tlsd_pkg::REC_HDR_TYPE), "record end did not rewind the header")

	// handshake parsing always has record bytes left
	`TLSD_NEVER(a_hs_rem_nonzero, (phase_q == tlsd_pkg::PH_MSGHDR || phase_q == tlsd_pkg::PH_MSGBODY) && rec_rem_q == 16'd0, "handshake phase with no record bytes left")

endmodule

@@ tb/sv/testbench.sv @@
// self-checking testbench for the tls record deframer with handshake parsing
`timescale 1ns / 100ps

module testbench;

	// content types used to build records besides handshake
	localparam logic [7:0] CT_ALERT    = 8'd21;
	localparam logic [7:0] CT_APP_DATA = 8'd23;

	// first register index the block does not decode
	localparam logic [tlsd_pkg::CFG_INDEX_W-1:0] FIRST_UNUSED_INDEX =
		tlsd_pkg::CFG_MIN_MAJOR_VERSION + 1'b1;

	localparam int     DRAIN_LIMIT  = 4000;      // cycles allowed for results to come back
	localparam int     TAIL_CYCLES  = 8;         // quiet cycles after the last result
	localparam longint TIMEOUT_NS   = 40000000;  // watchdog limit in ns, far above the slowest run
	localparam int     PHASE_BYTES  = 75;        // random bytes per register setting

	typedef logic [7:0] byte_q_t[$];

	// what the block reports for one stream byte
	typedef struct packed {
		tlsd_pkg::kind_t kind;
		logic [7:0]  content_type;
		logic [7:0]  version_major;
		logic [7:0]  version_minor;
		logic [15:0] payload_len;
		logic [7:0]  message_type;
		logic [23:0] message_len;
		logic        record_last;
		logic        message_last;
		tlsd_pkg::err_t err;
	} byte_report_t;

	logic clk;
	logic arst_n;

	tlsd_byte_if   stream_if ();
	tlsd_result_if result_if ();
	tlsd_cfg_if    cfg_if ();

	tls_record_handshake_deframer_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_if),
		.result (result_if),
		.cfg    (cfg_if)
	);

	// 20 ns clock
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// ---------------------------------------------------------------
	// deframer mirror: register copies and parse state
	// ---------------------------------------------------------------
	logic [15:0] cfg_max_len   = tlsd_pkg::MAX_RECORD_LEN_RST;
	logic [7:0]  cfg_min_major = tlsd_pkg::MIN_MAJOR_VERSION_RST;

	tlsd_pkg::phase_t ph  = tlsd_pkg::PH_RECHDR;
	logic [2:0]  hdr_idx   = tlsd_pkg::REC_HDR_TYPE;
	logic [7:0]  rec_type  = '0;
	logic [7:0]  rec_major = '0;
	logic [7:0]  rec_minor = '0;
	logic [15:0] rec_len   = '0;
	logic [15:0] rec_left  = '0;
	logic [1:0]  msg_idx   = tlsd_pkg::MSG_HDR_TYPE;
	logic [7:0]  hs_type   = '0;
	logic [23:0] msg_len   = '0;
	logic [23:0] msg_left  = '0;
	tlsd_pkg::err_t sticky = tlsd_pkg::ERR_NONE;

	// results predicted for accepted bytes, oldest first
	byte_report_t byte_reports[$];

	int  error_count     = 0;
	int  bytes_sent      = 0;
	int  records_sent    = 0;
	int  reg_writes      = 0;
	int  results_checked = 0;
	bit  idle_on         = 1'b1;
	int  stall_left      = 0;
	string closing_case  = "none";

	// any error locks the parser into discarding until reset
	function automatic void enter_discard(input tlsd_pkg::err_t code);
		sticky = code;
		ph = tlsd_pkg::PH_DISCARD;
	endfunction

	// the record is finished, next byte starts a new header
	function automatic void close_record();
		ph = tlsd_pkg::PH_RECHDR;
		hdr_idx = tlsd_pkg::REC_HDR_TYPE;
	endfunction

	// advance the mirror by one stream byte and return its expected report
	function automatic byte_report_t deframe_byte(input logic [7:0] b);
		byte_report_t r;
		logic [15:0]  len16;
		logic [23:0]  len24;

		r = '0;
		r.kind = tlsd_pkg::KIND_DISCARD;
		r.err = tlsd_pkg::ERR_NONE;
		case (ph)
			tlsd_pkg::PH_RECHDR: begin
				r.kind = tlsd_pkg::KIND_REC_HDR;
				case (hdr_idx)
					tlsd_pkg::REC_HDR_TYPE: begin
						// new record wipes everything left from the previous one
						rec_type  = b;
						rec_major = '0;
						rec_minor = '0;
						rec_len   = '0;
						rec_left  = '0;
						msg_idx   = tlsd_pkg::MSG_HDR_TYPE;
						hs_type   = '0;
						msg_len   = '0;
						msg_left  = '0;
						hdr_idx   = tlsd_pkg::REC_HDR_MAJOR;
					end
					tlsd_pkg::REC_HDR_MAJOR: begin
						rec_major = b;
						hdr_idx = tlsd_pkg::REC_HDR_MINOR;
					end
					tlsd_pkg::REC_HDR_MINOR: begin
						rec_minor = b;
						hdr_idx = tlsd_pkg::REC_HDR_LEN_H;
					end
					tlsd_pkg::REC_HDR_LEN_H: begin
						rec_left = {b, 8'h00};
						hdr_idx = tlsd_pkg::REC_HDR_LEN_H + 3'd1;
					end
					default: begin
						// last header byte: version check wins over length check
						len16 = rec_left | {8'h00, b};
						rec_left = '0;
						hdr_idx = tlsd_pkg::REC_HDR_TYPE;
						if (rec_major < cfg_min_major) begin
							r.err = tlsd_pkg::ERR_BAD_VERSION;
							enter_discard(tlsd_pkg::ERR_BAD_VERSION);
						end else if (len16 > cfg_max_len) begin
							r.err = tlsd_pkg::ERR_TOO_LONG;
							enter_discard(tlsd_pkg::ERR_TOO_LONG);
						end else begin
							rec_len = len16;
							rec_left = len16;
							if (len16 == 16'd0) begin
								r.record_last = 1'b1;
								close_record();
							end else if (rec_type == tlsd_pkg::HANDSHAKE_TYPE) begin
								ph = tlsd_pkg::PH_MSGHDR;
								msg_idx = tlsd_pkg::MSG_HDR_TYPE;
							end else begin
								ph = tlsd_pkg::PH_PAYLOAD;
							end
						end
					end
				endcase
			end
			tlsd_pkg::PH_PAYLOAD: begin
				r.kind = tlsd_pkg::KIND_PAYLOAD;
				rec_left = rec_left - 16'd1;
				if (rec_left == 16'd0) begin
					r.record_last = 1'b1;
					close_record();
				end
			end
			tlsd_pkg::PH_MSGHDR: begin
				r.kind = tlsd_pkg::KIND_HS_HDR;
				rec_left = rec_left - 16'd1;
				if (msg_idx == tlsd_pkg::MSG_HDR_TYPE) begin
					hs_type  = b;
					msg_len  = '0;
					msg_left = '0;
				end else if (msg_idx < tlsd_pkg::MSG_HDR_LAST) begin
					msg_left = {msg_left[15:0], b};
				end
				if (msg_idx < tlsd_pkg::MSG_HDR_LAST) begin
					msg_idx = msg_idx + 2'd1;
					// record ran out inside the message header
					if (rec_left == 16'd0) begin
						r.err = tlsd_pkg::ERR_HS_TRUNC;
						enter_discard(tlsd_pkg::ERR_HS_TRUNC);
					end
				end else begin
					len24 = {msg_left[15:0], b};
					msg_idx = tlsd_pkg::MSG_HDR_TYPE;
					msg_left = '0;
					if (len24 > {8'h00, rec_left}) begin
						r.err = tlsd_pkg::ERR_HS_OVERRUN;
						enter_discard(tlsd_pkg::ERR_HS_OVERRUN);
					end else begin
						msg_len = len24;
						msg_left = len24;
						if (len24 == 24'd0) begin
							// empty message ends on its own header
							r.message_last = 1'b1;
							if (rec_left == 16'd0) begin
								r.record_last = 1'b1;
								close_record();
							end
						end else begin
							ph = tlsd_pkg::PH_MSGBODY;
						end
					end
				end
			end
			tlsd_pkg::PH_MSGBODY: begin
				r.kind = tlsd_pkg::KIND_HS_BODY;
				rec_left = rec_left - 16'd1;
				msg_left = msg_left - 24'd1;
				if (msg_left == 24'd0) begin
					r.message_last = 1'b1;
					if (rec_left == 16'd0) begin
						r.record_last = 1'b1;
						close_record();
					end else begin
						ph = tlsd_pkg::PH_MSGHDR;
						msg_idx = tlsd_pkg::MSG_HDR_TYPE;
					end
				end else if (rec_left == 16'd0) begin
					r.err = tlsd_pkg::ERR_HS_OVERRUN;
					enter_discard(tlsd_pkg::ERR_HS_OVERRUN);
				end
			end
			default: begin
				r.kind = tlsd_pkg::KIND_DISCARD;
				r.err = sticky;
			end
		endcase
		r.content_type  = rec_type;
		r.version_major = rec_major;
		r.version_minor = rec_minor;
		r.payload_len   = rec_len;
		r.message_type  = hs_type;
		r.message_len   = msg_len;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// result side: random stall bursts and the field-by-field check
	// ---------------------------------------------------------------

	// random stall bursts while idling is on
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			result_if.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 13);
			result_if.ready <= 1'b0;
		end else begin
			result_if.ready <= 1'b1;
		end
	end

	task automatic check_field(input string name, input logic [23:0] want,
			input logic [23:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			error_count++;
		end
	endtask

	// every result request taken is matched against the oldest prediction
	always @(posedge clk) begin : check_results
		byte_report_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			if (byte_reports.size() == 0) begin
				$error("result request with no byte waiting for it");
				error_count++;
			end else begin
				want = byte_reports.pop_front();
				results_checked++;
				check_field("byte_kind", want.kind, result_if.byte_kind);
				check_field("content_type", want.content_type, result_if.content_type);
				check_field("version_major", want.version_major, result_if.version_major);
				check_field("version_minor", want.version_minor, result_if.version_minor);
				check_field("payload_len", want.payload_len, result_if.payload_len);
				check_field("message_type", want.message_type, result_if.message_type);
				check_field("message_len", want.message_len, result_if.message_len);
				check_field("record_last", want.record_last, result_if.record_last);
				check_field("message_last", want.message_last, result_if.message_last);
				check_field("error_code", want.err, result_if.error_code);
			end
		end
	end

	// ---------------------------------------------------------------
	// stimulus helpers; all are entered and left just after a falling edge
	// ---------------------------------------------------------------

	// one stream byte; valid is left high so back-to-back bytes need no dip
	task automatic send_byte(input logic [7:0] value);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			stream_if.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		stream_if.valid <= 1'b1;
		stream_if.byte_value <= value;
		@(posedge clk);
		while (!stream_if.ready) @(posedge clk);
		byte_reports.push_back(deframe_byte(value));
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_header(input logic [7:0] ctype, input logic [7:0] major,
			input logic [7:0] minor, input logic [15:0] len);
		send_byte(ctype);
		send_byte(major);
		send_byte(minor);
		send_byte(len[15:8]);
		send_byte(len[7:0]);
		records_sent++;
	endtask

	// header with the body's own length, then the body
	task automatic send_record(input logic [7:0] ctype, input logic [7:0] major,
			input logic [7:0] minor, input byte_q_t body);
		send_header(ctype, major, minor, 16'(body.size()));
		foreach (body[i])
			send_byte(body[i]);
	endtask

	// drop valid and wait for every outstanding result request
	task automatic wait_results_drained();
		int waited;
		waited = 0;
		stream_if.valid <= 1'b0;
		do begin
			@(negedge clk);
			waited++;
		end while (byte_reports.size() != 0 && waited < DRAIN_LIMIT);
		if (byte_reports.size() != 0) begin
			$error("%0d results never came back", byte_reports.size());
			error_count++;
			byte_reports.delete();
		end
	endtask

	// register write; only called with the stream idle and drained
	task automatic write_reg(input logic [tlsd_pkg::CFG_INDEX_W-1:0] reg_index,
			input logic [tlsd_pkg::CFG_DATA_W-1:0] reg_data);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= reg_index;
		cfg_if.data <= reg_data;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		case (reg_index)
			tlsd_pkg::CFG_MAX_RECORD_LEN:    cfg_max_len = reg_data;
			tlsd_pkg::CFG_MIN_MAJOR_VERSION: cfg_min_major = reg_data[7:0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
		@(negedge clk);
	endtask

	// well-formed handshake payload of at most cap bytes, possibly empty
	function automatic byte_q_t handshake_body(input int cap);
		byte_q_t     body;
		int          room;
		logic [23:0] mlen;
		while (body.size() + 4 <= cap && $urandom_range(0, 3) != 0) begin
			room = cap - body.size() - 4;
			if (room > 12 && $urandom_range(0, 7) != 0)
				room = 12;
			mlen = 24'($urandom_range(0, room));
			body.push_back(8'($urandom_range(0, 255)));
			body.push_back(mlen[23:16]);
			body.push_back(mlen[15:8]);
			body.push_back(mlen[7:0]);
			repeat (mlen) body.push_back(8'($urandom_range(0, 255)));
		end
		return body;
	endfunction

	function automatic byte_q_t random_bytes(input int count);
		byte_q_t body;
		repeat (count) body.push_back(8'($urandom_range(0, 255)));
		return body;
	endfunction

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// reset register values: handshake record with an empty and a one-byte message,
	// then an application record that must clear the message fields, then empty records
	task automatic test_basic_records();
		byte_q_t body;
		body = {8'hFF, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'hAA};
		send_record(tlsd_pkg::HANDSHAKE_TYPE, 8'd3, 8'd4, body);
		body = {8'h00, 8'hFF};
		send_record(CT_APP_DATA, 8'd3, 8'd3, body);
		body.delete();
		send_record(tlsd_pkg::HANDSHAKE_TYPE, 8'd3, 8'd3, body);
		send_record(CT_ALERT, 8'd3, 8'd1, body);
		wait_results_drained();
	endtask

	// both registers at their extremes, plus a write to an index nobody decodes
	task automatic test_register_extremes();
		byte_q_t body;
		write_reg(tlsd_pkg::CFG_MAX_RECORD_LEN, 16'd0);
		write_reg(tlsd_pkg::CFG_MIN_MAJOR_VERSION, 16'hFF00);
		body.delete();
		send_record(CT_APP_DATA, 8'd0, 8'hFF, body);
		send_record(tlsd_pkg::HANDSHAKE_TYPE, 8'd0, 8'd0, body);
		wait_results_drained();

		write_reg(tlsd_pkg::CFG_MAX_RECORD_LEN, 16'hFFFF);
		write_reg(tlsd_pkg::CFG_MIN_MAJOR_VERSION, 16'h00FF);
		write_reg(FIRST_UNUSED_INDEX, 16'h0000);
		// two empty messages fill the record exactly
		body = {8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00};
		send_record(tlsd_pkg::HANDSHAKE_TYPE, 8'hFF, 8'h00, body);
		body = {8'hFF};
		send_record(CT_APP_DATA, 8'hFF, 8'hFF, body);
		wait_results_drained();
	endtask

	// well-formed records with random content under several register settings
	task automatic test_random_traffic();
		int          stop_at;
		int          cap;
		logic [15:0] max_len;
		logic [7:0]  min_major;
		logic [7:0]  ctype;
		byte_q_t     body;
		for (int setting = 0; setting < 6; setting++) begin
			case (setting)
				0: begin
					max_len = 16'd0;
					min_major = 8'hFF;
				end
				1: begin
					max_len = 16'hFFFF;
					min_major = 8'h00;
				end
				2: begin
					// too short for any non-empty handshake message
					max_len = 16'($urandom_range(1, 3));
					min_major = 8'($urandom_range(0, 255));
				end
				3: begin
					max_len = tlsd_pkg::MAX_RECORD_LEN_RST;
					min_major = tlsd_pkg::MIN_MAJOR_VERSION_RST;
				end
				default: begin
					max_len = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(4, 60))
						: 16'($urandom_range(0, 65535));
					min_major = 8'($urandom_range(0, 255));
				end
			endcase
			write_reg(tlsd_pkg::CFG_MIN_MAJOR_VERSION, {8'($urandom_range(0, 255)), min_major});
			write_reg(tlsd_pkg::CFG_MAX_RECORD_LEN, max_len);
			if ($urandom_range(0, 1) == 0)
				write_reg(tlsd_pkg::CFG_INDEX_W'($urandom_range(FIRST_UNUSED_INDEX, 255)),
					16'($urandom_range(0, 65535)));
			stop_at = bytes_sent + PHASE_BYTES;
			while (bytes_sent < stop_at) begin
				cap = (cfg_max_len < 16'd40) ? int'(cfg_max_len) : 40;
				if ($urandom_range(0, 19) == 0)
					cap = (cfg_max_len < 16'd300) ? int'(cfg_max_len) : 300;
				if ($urandom_range(0, 9) < 4) begin
					ctype = tlsd_pkg::HANDSHAKE_TYPE;
					body = handshake_body(cap);
				end else begin
					ctype = 8'($urandom_range(0, 255));
					if (ctype == tlsd_pkg::HANDSHAKE_TYPE)
						ctype = CT_APP_DATA;
					body = random_bytes($urandom_range(0, cap));
				end
				send_record(ctype, 8'($urandom_range(cfg_min_major, 255)),
					8'($urandom_range(0, 255)), body);
			end
			wait_results_drained();
		end
	endtask

	// one handshake record of two messages sent with no gaps at all,
	// idling off from here on
	task automatic test_back_to_back();
		byte_q_t body;
		idle_on = 1'b0;
		write_reg(tlsd_pkg::CFG_MAX_RECORD_LEN, 16'hFFFF);
		write_reg(tlsd_pkg::CFG_MIN_MAJOR_VERSION, {8'h00, tlsd_pkg::MIN_MAJOR_VERSION_RST});
		body = {8'h0B, 8'h00, 8'h00, 8'h30};
		repeat (48) body.push_back(8'($urandom_range(0, 255)));
		body.push_back(8'h14);
		body.push_back(8'h00);
		body.push_back(8'h00);
		body.push_back(8'h0C);
		repeat (12) body.push_back(8'($urandom_range(0, 255)));
		send_record(tlsd_pkg::HANDSHAKE_TYPE, 8'd3, 8'd3, body);
		wait_results_drained();
	endtask

	// one error case picked at random, then bytes that must all be discarded
	task automatic test_error_then_discard();
		tlsd_pkg::err_t pick;
		logic [7:0]  bound;
		logic [15:0] len;
		logic [23:0] mlen;
		byte_q_t     body;
		pick = tlsd_pkg::err_t'($urandom_range(int'(tlsd_pkg::ERR_BAD_VERSION),
			int'(tlsd_pkg::ERR_HS_OVERRUN)));
		closing_case = pick.name();
		bound = 8'($urandom_range(1, 255));
		write_reg(tlsd_pkg::CFG_MIN_MAJOR_VERSION, {8'h00, bound});
		write_reg(tlsd_pkg::CFG_MAX_RECORD_LEN, 16'd100);
		case (pick)
			tlsd_pkg::ERR_BAD_VERSION: begin
				body = random_bytes($urandom_range(0, 20));
				send_record(tlsd_pkg::HANDSHAKE_TYPE, 8'($urandom_range(0, bound - 8'd1)),
					8'd3, body);
			end
			tlsd_pkg::ERR_TOO_LONG: begin
				len = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'($urandom_range(101, 65535));
				send_header(CT_APP_DATA, 8'($urandom_range(bound, 255)), 8'd3, len);
			end
			tlsd_pkg::ERR_HS_TRUNC: begin
				// record ends before the message header does
				len = 16'($urandom_range(1, 3));
				send_header(tlsd_pkg::HANDSHAKE_TYPE, 8'($urandom_range(bound, 255)), 8'd3, len);
				repeat (len) send_byte(8'($urandom_range(0, 255)));
			end
			default: begin
				// message body claims more than the record holds
				len = 16'($urandom_range(4, 100));
				mlen = ($urandom_range(0, 1) == 0) ? 24'hFFFFFF
					: 24'($urandom_range(len - 16'd3, 24'hFFFFFF));
				send_header(tlsd_pkg::HANDSHAKE_TYPE, 8'($urandom_range(bound, 255)), 8'd3, len);
				send_byte(8'($urandom_range(0, 255)));
				send_byte(mlen[23:16]);
				send_byte(mlen[15:8]);
				send_byte(mlen[7:0]);
			end
		endcase
		// a well-formed record after the error must be discarded as well
		body = random_bytes(4);
		send_record(CT_APP_DATA, 8'hFF, 8'd3, body);
		repeat ($urandom_range(20, 40)) send_byte(8'($urandom_range(0, 255)));
		wait_results_drained();
	endtask

	// ---------------------------------------------------------------
	// sequence
	// ---------------------------------------------------------------
	initial begin
		stream_if.valid = 1'b0;
		stream_if.byte_value = '0;
		result_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data = '0;
		arst_n = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_basic_records();
		test_register_extremes();
		test_random_traffic();
		test_back_to_back();
		test_error_then_discard();

		// anything that shows up now has no byte behind it
		repeat (TAIL_CYCLES) @(negedge clk);
		$display("stream of %0d bytes in %0d records, %0d register writes, %0d results checked",
			bytes_sent, records_sent, reg_writes, results_checked);
		$display("run closed with a %s error and the discard that follows it", closing_case);
		if (error_count == 0) begin
			$display("** tls_record_handshake_deframer_top: PASSED **");
		end else begin
			$display("** tls_record_handshake_deframer_top: FAILED **");
		end
		$finish;
	end

	// watchdog against a hung handshake
	initial begin
		#(TIMEOUT_NS);
		$display("timeout with %0d results outstanding", byte_reports.size());
		$display("** tls_record_handshake_deframer_top: FAILED **");
		$finish;
	end

endmodule

@@ tls_record_handshake_deframer_top.f @@
+incdir+hdl
hdl/tlsd_pkg.sv
hdl/tlsd_byte_if.sv
hdl/tlsd_result_if.sv
hdl/tlsd_cfg_if.sv
hdl/tls_record_handshake_deframer_top.sv
tb/sv/testbench.sv
